// ===== src/rvc_pkg.sv =====
// Package with shared types and constants for the RV32I execute block.
package rvc_pkg;

  localparam int unsigned RegCountDef = 32;

  // Memory access codes.
  localparam logic [1:0] AccNone  = 2'd0;
  localparam logic [1:0] AccRead  = 2'd1;
  localparam logic [1:0] AccWrite = 2'd2;

  // Status codes.
  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StUnknown = 3'd1;
  localparam logic [2:0] StEcall  = 3'd2;
  localparam logic [2:0] StEbreak = 3'd3;
  localparam logic [2:0] StSeqErr = 3'd4;

  // Major opcodes.
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpFence  = 7'h0f;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [31:0] InstrEcall  = 32'h0000_0073;
  localparam logic [31:0] InstrEbreak = 32'h0010_0073;

  // Result item as one bundle.
  typedef struct packed {
    logic [1:0]  mem_access;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] mem_wdata;
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic [2:0]  status;
  } result_t;

endpackage

// ===== src/rvc_regfile.sv =====
// Register file: synchronous two-read, one-write memory with registered read ports.
module rvc_regfile import rvc_pkg::*; #(
  parameter int unsigned REG_COUNT = RegCountDef
) (
  input  logic        clk,
  input  logic        rd_en,
  input  logic [4:0]  rd_addr_a,
  input  logic [4:0]  rd_addr_b,
  output logic [31:0] rd_data_a,
  output logic [31:0] rd_data_b,
  input  logic        wr_en,
  input  logic [4:0]  wr_addr,
  input  logic [31:0] wr_data
);

  logic [31:0] mem [REG_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_addr) < REG_COUNT)) begin
      mem[wr_addr[$clog2(REG_COUNT)-1:0]] <= wr_data;
    end
  end

  // Registered read ports; the data holds until the next enabled read.
  // Out-of-range reads return zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= (32'(rd_addr_a) < REG_COUNT) ? mem[rd_addr_a[$clog2(REG_COUNT)-1:0]] : '0;
      rd_data_b <= (32'(rd_addr_b) < REG_COUNT) ? mem[rd_addr_b[$clog2(REG_COUNT)-1:0]] : '0;
    end
  end

endmodule

// ===== src/rv32i_integer_core_step.sv =====
// Top level of the RV32I execute block with register file, PC and load tracking.
// Each item is held in the execute and output registers in turn: the register
// file is a synchronous memory read in the accept cycle, and the execute stage
// works on the read data the next cycle, with a write-back forwarding path for
// back-to-back dependencies. Throughput is one item per cycle while out_ready
// stays high. A load issues a read request; the following data item completes it.
// Because register contents are undefined after reset, the file is cleared by a
// pass over all REG_COUNT entries after reset, during which no item is accepted.
module rv32i_integer_core_step import rvc_pkg::*; #(
  parameter int unsigned REG_COUNT = RegCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_mem_access,
  output logic [31:0] out_mem_addr,
  output logic [1:0]  out_mem_size,
  output logic [31:0] out_mem_wdata,
  output logic [31:0] out_next_pc,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic        out_dest_written,
  output logic [2:0]  out_status
);

  // Clearing pass state.
  logic        clr_busy_r;
  logic [5:0]  clr_cnt_r;

  // Execute stage registers.
  logic        ex_valid_r;
  logic        ex_req_type_r;
  logic [31:0] ex_instr_r;
  logic [31:0] ex_ldata_r;

  // Architectural control state.
  logic [31:0] pc_r;
  logic        ld_pend_r;
  logic [4:0]  ld_dest_r;
  logic [2:0]  ld_kind_r;

  // Output register.
  logic        out_valid_r;
  result_t     res_r;

  // Last write-back, for forwarding into the stage that reads behind it.
  logic        fw_en_r;
  logic [4:0]  fw_idx_r;
  logic [31:0] fw_val_r;

  logic [31:0] rf_a, rf_b;
  logic        wb_en;
  logic [4:0]  wb_idx;
  logic [31:0] wb_val;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  logic        ex_go;
  logic        accept;
  result_t     res;

  // The execute stage may advance when the output register is free or drained.
  assign ex_go    = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!ex_valid_r || ex_go);
  assign accept   = in_valid && in_ready;

  assign rf_we = clr_busy_r || wb_en;
  assign rf_wa = clr_busy_r ? clr_cnt_r[4:0] : wb_idx;
  assign rf_wd = clr_busy_r ? '0 : wb_val;

  rvc_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (in_instr_word[19:15]),
    .rd_addr_b (in_instr_word[24:20]),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (rf_we),
    .wr_addr   (rf_wa),
    .wr_data   (rf_wd)
  );

  // Execute logic.
  logic [6:0]  opc;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] a, b, immi, imms, immb, immj, immu, alu_b, val, pc4;
  logic        hasdest, alt, take;
  logic [31:0] w;

  function automatic logic [31:0] rd_fix(input logic [4:0] idx, input logic [31:0] mem_v,
                                         input logic fe, input logic [4:0] fi,
                                         input logic [31:0] fv);
    logic [31:0] r;
    if (idx == 5'd0 || 32'(idx) >= REG_COUNT) r = '0;
    else if (fe && fi == idx) r = fv;
    else r = mem_v;
    return r;
  endfunction

  always_comb begin
    w    = ex_instr_r;
    opc  = w[6:0];
    rd   = w[11:7];
    f3   = w[14:12];
    rs1  = w[19:15];
    rs2  = w[24:20];
    f7   = w[31:25];
    a    = rd_fix(rs1, rf_a, fw_en_r, fw_idx_r, fw_val_r);
    b    = rd_fix(rs2, rf_b, fw_en_r, fw_idx_r, fw_val_r);
    immi = {{20{w[31]}}, w[31:20]};
    imms = {{20{w[31]}}, w[31:25], w[11:7]};
    immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    immu = {w[31:12], 12'b0};
    pc4  = pc_r + 32'd4;
    res  = '0;
    res.next_pc = pc_r;
    hasdest = 1'b0;
    val  = '0;
    alt  = 1'b0;
    alu_b = b;
    take = 1'b0;
    wb_en = 1'b0;
    wb_idx = '0;
    wb_val = '0;

    if (ex_req_type_r) begin
      // Load data completion.
      if (!ld_pend_r) begin
        res.status = StSeqErr;
      end else begin
        unique case (ld_kind_r)
          3'd0:    val = {{24{ex_ldata_r[7]}}, ex_ldata_r[7:0]};
          3'd1:    val = {{16{ex_ldata_r[15]}}, ex_ldata_r[15:0]};
          3'd4:    val = {24'b0, ex_ldata_r[7:0]};
          3'd5:    val = {16'b0, ex_ldata_r[15:0]};
          default: val = ex_ldata_r;
        endcase
        hasdest = 1'b1;
        rd = ld_dest_r;
      end
    end else if (ld_pend_r) begin
      res.status = StSeqErr;
    end else begin
      res.next_pc = pc4;
      unique case (opc)
        OpLui:   begin hasdest = 1'b1; val = immu; end
        OpAuipc: begin hasdest = 1'b1; val = pc_r + immu; end
        OpJal:   begin hasdest = 1'b1; val = pc4; res.next_pc = pc_r + immj; end
        OpJalr: begin
          if (f3 != 3'd0) res.status = StUnknown;
          else begin
            hasdest = 1'b1; val = pc4;
            res.next_pc = (a + immi) & ~32'd1;
          end
        end
        OpBranch: begin
          unique case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = ($signed(a) < $signed(b));
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = (a < b);
            3'd7: take = (a >= b);
            default: res.status = StUnknown;
          endcase
          if (take) res.next_pc = pc_r + immb;
        end
        OpLoad: begin
          if (f3 == 3'd3 || f3 > 3'd5) res.status = StUnknown;
          else begin
            res.mem_access = AccRead;
            res.mem_addr   = a + immi;
            res.mem_size   = {1'b0, f3[0]} | {f3[1], 1'b0};
          end
        end
        OpStore: begin
          if (f3 > 3'd2) res.status = StUnknown;
          else begin
            res.mem_access = AccWrite;
            res.mem_addr   = a + imms;
            res.mem_size   = f3[1:0];
            res.mem_wdata  = b;
          end
        end
        OpImm: begin
          if ((f3 == 3'd1 && f7 != 7'h00) ||
              (f3 == 3'd5 && f7 != 7'h00 && f7 != 7'h20)) res.status = StUnknown;
          else begin
            hasdest = 1'b1;
            alt = (f3 == 3'd5 && f7 == 7'h20);
            alu_b = immi;
          end
        end
        OpReg: begin
          if (f7 != 7'h00 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))
            res.status = StUnknown;
          else begin
            hasdest = 1'b1;
            alt = (f7 == 7'h20);
          end
        end
        OpFence: if (f3 != 3'd0) res.status = StUnknown;
        OpSystem: begin
          if (w == InstrEcall) res.status = StEcall;
          else if (w == InstrEbreak) res.status = StEbreak;
          else res.status = StUnknown;
        end
        default: res.status = StUnknown;
      endcase
      // Shared ALU for the register and immediate groups.
      if (hasdest && (opc == OpImm || opc == OpReg)) begin
        unique case (f3)
          3'd0: val = alt ? a - alu_b : a + alu_b;
          3'd1: val = a << alu_b[4:0];
          3'd2: val = {31'b0, $signed(a) < $signed(alu_b)};
          3'd3: val = {31'b0, a < alu_b};
          3'd4: val = a ^ alu_b;
          3'd5: val = alt ? 32'($signed(a) >>> alu_b[4:0]) : a >> alu_b[4:0];
          3'd6: val = a | alu_b;
          default: val = a & alu_b;
        endcase
      end
    end

    if (hasdest && rd != 5'd0 && 32'(rd) < REG_COUNT) begin
      wb_en = ex_go;
      wb_idx = rd;
      wb_val = val;
      res.dest_written = 1'b1;
      res.dest_index = rd;
      res.dest_value = val;
    end
  end

  // Control state: clearing pass, stage and output valid, forward enable, PC and load tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      ld_pend_r   <= 1'b0;
      ld_dest_r   <= '0;
      ld_kind_r   <= '0;
      fw_en_r     <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 6'd1;
        if (32'(clr_cnt_r) == REG_COUNT - 1) clr_busy_r <= 1'b0;
      end
      if (accept) ex_valid_r <= 1'b1;
      else if (ex_go) ex_valid_r <= 1'b0;
      if (ex_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // Forward only across an accept so reads see the last write.
      if (accept) fw_en_r <= wb_en;
      if (ex_go) begin
        pc_r <= res.next_pc;
        if (ex_req_type_r) ld_pend_r <= 1'b0;
        else if (res.mem_access == AccRead) begin
          ld_pend_r <= 1'b1;
          ld_dest_r <= rd;
          ld_kind_r <= f3;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_req_type_r <= in_req_type;
      ex_instr_r    <= in_instr_word;
      ex_ldata_r    <= in_load_data;
      fw_idx_r      <= wb_idx;
      fw_val_r      <= wb_val;
    end
    if (ex_go) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_mem_access   = res_r.mem_access;
  assign out_mem_addr     = res_r.mem_addr;
  assign out_mem_size     = res_r.mem_size;
  assign out_mem_wdata    = res_r.mem_wdata;
  assign out_next_pc      = res_r.next_pc;
  assign out_dest_index   = res_r.dest_index;
  assign out_dest_value   = res_r.dest_value;
  assign out_dest_written = res_r.dest_written;
  assign out_status       = res_r.status;

endmodule
